### rtl/core/qrm_pkg.sv
package qrm_pkg;

  // Largest component magnitude fed to the multipliers is 2^(MagBits-1).
  localparam int unsigned MagBits = 16;

  // Sideband that travels with each entry through the divider pipeline.
  typedef struct packed {
    logic neg;    // entry is negative
    logic degen;  // zero quaternion: give the identity entry
    logic diag;   // entry sits on the main diagonal
  } div_tag_t;

endpackage

### rtl/core/qrm_div.sv
module qrm_div #(
  parameter int unsigned CompWidth = 16,
  parameter int unsigned FracBits  = 14,
  parameter int unsigned QWidth    = 33
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  qrm_pkg::div_tag_t           tag_i,
  input  logic [QWidth-1:0]           num_i,  // |numerator|, never above den_i
  input  logic [QWidth-1:0]           den_i,
  output logic signed [CompWidth-1:0] entry_o
);
  import qrm_pkg::*;

  localparam int unsigned Steps = FracBits + 1;
  localparam int unsigned NW    = QWidth + FracBits + 1;
  localparam int unsigned RW    = ((FracBits + 2 > CompWidth) ? FracBits + 2 : CompWidth) + 1;
  localparam logic signed [RW-1:0] Hi  = RW'((64'(1) << (CompWidth - 1)) - 64'(1));
  localparam logic signed [RW-1:0] Lo  = -Hi - RW'(1);
  localparam logic signed [RW-1:0] One = RW'(64'(1) << FracBits);

  logic [QWidth-1:0] rem_q [Steps+1];
  logic [QWidth-1:0] den_q [Steps+1];
  logic [Steps-1:0]  quo_q [Steps+1];
  logic [Steps-1:0]  low_q [Steps+1];
  div_tag_t          tag_q [Steps+1];

  logic [NW-1:0] nbias;
  logic signed [CompWidth-1:0] entry_d, entry_q;

  // Rounded numerator; its high part is already below the divisor.
  assign nbias = (NW'(num_i) << FracBits) + NW'(den_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= QWidth'(nbias >> Steps);
      low_q[0] <= nbias[Steps-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_step
    logic [QWidth:0] trial;
    logic            ge;
    assign trial = {rem_q[k-1], low_q[k-1][Steps-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? QWidth'(trial - {1'b0, den_q[k-1]}) : QWidth'(trial);
        low_q[k] <= low_q[k-1] << 1;
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][Steps-2:0], ge};
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_comb begin
    logic signed [RW-1:0] r;
    r = RW'({1'b0, quo_q[Steps]});
    if (tag_q[Steps].neg) r = -r;
    if (tag_q[Steps].degen) r = tag_q[Steps].diag ? One : '0;
    if (r > Hi) r = Hi;
    if (r < Lo) r = Lo;
    entry_d = CompWidth'(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en_i) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

### rtl/core/quaternion_to_rotation_matrix_core.sv
// Quaternion (w, x, y, z) in, 3x3 rotation matrix out, both in signed fixed
// point with FRAC_BITS fraction bits. The input need not be unit length: each
// entry is the exact unit-quaternion value, rounded to nearest with ties away
// from zero. A zero quaternion gives the identity matrix with tuser (the
// degenerate flag) high. One quaternion is taken every clock cycle unless the
// output stalls; the nine restoring dividers, one per entry, resolve one
// quotient bit per stage. A low m_axis_tready_i while a matrix waits at the
// output stalls the whole pipeline without losing anything.
module quaternion_to_rotation_matrix_core #(
  parameter int unsigned COMP_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // {qz, qy, qx, qw} from the lowest bit up: qw, qx, qy, qz; zero padded
  input  logic [((4*COMP_WIDTH+7)/8)*8-1:0]         s_axis_tdata_i,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // lowest bit up: e00, e01, e02, e10, e11, e12, e20, e21, e22; zero padded
  output logic [((9*COMP_WIDTH+7)/8)*8-1:0]         m_axis_tdata_o,
  // bit 0: degenerate
  output logic                                      m_axis_tuser_o,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i
);
  import qrm_pkg::*;

  localparam int unsigned CW    = COMP_WIDTH;
  localparam int unsigned MagW  = (CW > MagBits) ? MagBits : CW;
  localparam int unsigned MaxSh = (CW > MagBits) ? CW - MagBits : 0;
  localparam int unsigned PW    = 2 * MagW + 2;
  localparam int unsigned SW    = 2 * MagW + 3;
  localparam int unsigned QW    = 2 * MagW + 1;
  localparam int unsigned Depth = FRAC_BITS + 7;
  localparam int unsigned OutW  = ((9 * CW + 7) / 8) * 8;
  localparam logic [63:0] MagLimit = 64'(1) << (MagBits - 1);

  logic en;
  logic [Depth-1:0] vld_q;
  logic [Depth-2:0] dgn_q;

  assign en = ~vld_q[Depth-1] | m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid_i};
    end
  end

  // Stage 0: capture components
  logic [CW-1:0] comp_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) comp_q[i] <= s_axis_tdata_i[i*CW +: CW];
    end
  end

  // Stage 1: magnitudes, common right shift for wide components, signs back
  logic [CW-1:0]          mag [4];
  logic [3:0]             sgn;
  logic [CW-1:0]          maxm;
  logic [MagW-1:0]        smag [4];
  logic signed [MagW:0]   c_d [4];
  logic signed [MagW:0]   c_q [4];

  always_comb begin
    maxm = '0;
    for (int i = 0; i < 4; i++) begin
      sgn[i] = comp_q[i][CW-1];
      mag[i] = sgn[i] ? -comp_q[i] : comp_q[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    for (int i = 0; i < 4; i++) smag[i] = MagW'(mag[i]);
    // pick the least shift that brings every magnitude within range
    for (int s = MaxSh; s >= 0; s--) begin
      if (64'(maxm >> s) <= MagLimit) begin
        for (int i = 0; i < 4; i++) smag[i] = MagW'(mag[i] >> s);
      end
    end
    for (int i = 0; i < 4; i++) begin
      c_d[i] = sgn[i] ? -$signed({1'b0, smag[i]}) : $signed({1'b0, smag[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= c_d;
      dgn_q <= {dgn_q[Depth-3:0], (maxm == '0)};
    end
  end

  // Stage 2: pair products (w, x, y, z at index 0..3)
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= PW'(c_q[0] * c_q[0]);
      xx_q <= PW'(c_q[1] * c_q[1]);
      yy_q <= PW'(c_q[2] * c_q[2]);
      zz_q <= PW'(c_q[3] * c_q[3]);
      xy_q <= PW'(c_q[1] * c_q[2]);
      xz_q <= PW'(c_q[1] * c_q[3]);
      yz_q <= PW'(c_q[2] * c_q[3]);
      xw_q <= PW'(c_q[1] * c_q[0]);
      yw_q <= PW'(c_q[2] * c_q[0]);
      zw_q <= PW'(c_q[3] * c_q[0]);
    end
  end

  // Stage 3: squared norm and the nine numerators as sign and magnitude
  logic signed [SW-1:0] qs;
  logic signed [SW-1:0] num [9];
  logic [QW-1:0]        anum_q [9];
  logic [8:0]           nneg_q;
  logic [QW-1:0]        qn_q;

  always_comb begin
    qs = SW'(ww_q) + SW'(xx_q) + SW'(yy_q) + SW'(zz_q);
    num[0] = qs - 2 * (SW'(yy_q) + SW'(zz_q));
    num[1] = 2 * (SW'(xy_q) + SW'(zw_q));
    num[2] = 2 * (SW'(xz_q) - SW'(yw_q));
    num[3] = 2 * (SW'(xy_q) - SW'(zw_q));
    num[4] = qs - 2 * (SW'(xx_q) + SW'(zz_q));
    num[5] = 2 * (SW'(yz_q) + SW'(xw_q));
    num[6] = 2 * (SW'(xz_q) + SW'(yw_q));
    num[7] = 2 * (SW'(yz_q) - SW'(xw_q));
    num[8] = qs - 2 * (SW'(xx_q) + SW'(yy_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qn_q <= QW'(qs);
      for (int i = 0; i < 9; i++) begin
        nneg_q[i] <= num[i][SW-1];
        anum_q[i] <= num[i][SW-1] ? QW'(-num[i]) : QW'(num[i]);
      end
    end
  end

  // Stages 4 on: one divider per entry
  logic signed [CW-1:0] entry [9];
  for (genvar e = 0; e < 9; e++) begin : g_div
    div_tag_t tag;
    assign tag = '{neg: nneg_q[e], degen: dgn_q[2], diag: (e % 4 == 0)};
    qrm_div #(
      .CompWidth (CW),
      .FracBits  (FRAC_BITS),
      .QWidth    (QW)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .tag_i   (tag),
      .num_i   (anum_q[e]),
      .den_i   (qn_q),
      .entry_o (entry[e])
    );
  end

  logic [9*CW-1:0] flat;
  always_comb begin
    for (int e = 0; e < 9; e++) flat[e*CW +: CW] = entry[e];
  end

  assign m_axis_tdata_o  = OutW'(flat);
  assign m_axis_tuser_o  = dgn_q[Depth-2];
  assign m_axis_tvalid_o = vld_q[Depth-1];

endmodule

### test/tb_quaternion_to_rotation_matrix_core.sv
`timescale 1ns / 100ps

module tb_quaternion_to_rotation_matrix_core;

  localparam int unsigned CW = 16;
  localparam int unsigned FB = 14;
  localparam int unsigned DW_IN = ((4*CW+7)/8)*8;
  localparam int unsigned DW_OUT = ((9*CW+7)/8)*8;
  localparam int unsigned LATENCY = FB + 7;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [DW_OUT-1:0] mat;
    logic              degen;
  } matrix_t;

  logic clk_i;
  logic rst_ni;
  logic [DW_IN-1:0] s_axis_tdata_i;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [DW_OUT-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;

  quaternion_to_rotation_matrix_core #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk_i, .rst_ni, .s_axis_tdata_i, .s_axis_tvalid_i, .s_axis_tready_o,
    .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tvalid_o, .m_axis_tready_i
  );

  matrix_t expected_mats[$];
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit hold_recv = 0;
  longint cycle_count = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** quaternion_to_rotation_matrix_core: FAILED **");
      $finish;
    end
  end

  // round(n * 2^FB / q), nearest, ties away from zero, then saturate
  function automatic logic [CW-1:0] scale_entry(longint n, longint q);
    longint a, v, hi, lo;
    a = (n < 0) ? -n : n;
    v = ((a <<< FB) + (q >>> 1)) / q;
    if (n < 0) v = -v;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic matrix_t rotation_of(logic [DW_IN-1:0] d);
    matrix_t r;
    longint w, x, y, z, q;
    longint n[9];
    w = longint'($signed(d[0*CW +: CW]));
    x = longint'($signed(d[1*CW +: CW]));
    y = longint'($signed(d[2*CW +: CW]));
    z = longint'($signed(d[3*CW +: CW]));
    r.mat = '0;
    if (w == 0 && x == 0 && y == 0 && z == 0) begin
      r.degen = 1'b1;
      for (int i = 0; i < 9; i++)
        r.mat[i*CW +: CW] = (i % 4 == 0) ? CW'(1 << FB) : '0;
      return r;
    end
    r.degen = 1'b0;
    q = w*w + x*x + y*y + z*z;
    n[0] = q - 2*(y*y + z*z);
    n[1] = 2*(x*y + z*w);
    n[2] = 2*(x*z - y*w);
    n[3] = 2*(x*y - z*w);
    n[4] = q - 2*(x*x + z*z);
    n[5] = 2*(y*z + x*w);
    n[6] = 2*(x*z + y*w);
    n[7] = 2*(y*z - x*w);
    n[8] = q - 2*(x*x + y*y);
    for (int i = 0; i < 9; i++) r.mat[i*CW +: CW] = scale_entry(n[i], q);
    return r;
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    matrix_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected transfer data=%h user=%b", $time,
                 m_axis_tdata_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        e = expected_mats.pop_front();
        for (int i = 0; i < 9; i++)
          if (m_axis_tdata_o[i*CW +: CW] !== e.mat[i*CW +: CW]) begin
            $display("%0t: entry %0d expected %h actual %h", $time, i,
                     e.mat[i*CW +: CW], m_axis_tdata_o[i*CW +: CW]);
            fail_count++;
          end
        if (m_axis_tuser_o !== e.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, e.degen,
                   m_axis_tuser_o);
          fail_count++;
        end
      end
    end
  end

  // called at a falling edge; leaves tvalid high for the next call to reuse
  task automatic send_quat(logic [CW-1:0] w, logic [CW-1:0] x,
                           logic [CW-1:0] y, logic [CW-1:0] z);
    logic [DW_IN-1:0] d;
    d = '0;
    d[4*CW-1:0] = {z, y, x, w};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata_i <= d;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_mats.push_back(rotation_of(d));
    @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return CW'($urandom_range(3));
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      3: return CW'(-$signed(CW'($urandom_range(40))));
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [CW-1:0] mx, mn, one;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    one = CW'(1 << FB);
    send_quat(0, 0, 0, 0);
    send_quat(one, 0, 0, 0);
    send_quat(0, one, 0, 0);
    send_quat(0, 0, one, 0);
    send_quat(0, 0, 0, one);
    send_quat(mx, mx, mx, mx);
    send_quat(mn, mn, mn, mn);
    send_quat(mn, mx, mn, mx);
    send_quat(mn, 0, 0, 0);
    send_quat(0, 0, 0, mn);
    send_quat(1, 0, 0, 0);
    send_quat(0, 1, 1, 0);
    send_quat(16'hffff, 1, 16'hffff, 1);
    send_quat(one, one, 0, 0);
    send_quat(3, 1, 0, 0);
    send_quat(mx, 1, 0, 0);
  endtask

  task automatic test_random(int unsigned count);
    for (int i = 0; i < count; i++)
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (120) @(negedge clk_i);
        hold_recv = 1'b0;
      end
      test_random(80);
    join
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 60;
    test_directed();
    test_random(220);
    send_idle_pct = 60;
    recv_idle_pct = 7;
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(220);
    s_axis_tvalid_i <= 1'b0;

    while (expected_mats.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0 && expected_mats.size() == 0)
      $display("** quaternion_to_rotation_matrix_core: PASSED **");
    else
      $display("** quaternion_to_rotation_matrix_core: FAILED **");
    $finish;
  end

endmodule
